// ===== hdl/x86_div_idiv_unit_defines.svh =====
// Assertion macros used by the checker of the divide unit.
`ifndef X86_DIV_IDIV_UNIT_DEFINES_SVH
`define X86_DIV_IDIV_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define XDIV_ASSERT_SAME(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define XDIV_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

// Checked during reset as well, for properties about reset itself.
`define XDIV_ASSERT_RESET(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ===== hdl/xdiv_pkg.sv =====
// Types and constants shared by the divide unit's modules.
package xdiv_pkg;

  typedef enum logic [1:0] {
    OP_DIVU8  = 2'd0,
    OP_DIVS8  = 2'd1,
    OP_DIVU16 = 2'd2,
    OP_DIVS16 = 2'd3
  } op_t;

  // Quotient magnitude limits for the signed operations.
  localparam logic [15:0] SB_Q_POS_MAX = 16'h007f;
  localparam logic [15:0] SB_Q_NEG_MAX = 16'h0080;
  localparam logic [15:0] SW_Q_POS_MAX = 16'h7fff;
  localparam logic [15:0] SW_Q_NEG_MAX = 16'h8000;
  localparam logic [31:0] SW_MIN_DIVIDEND = 32'h8000_0000;

  // Classified divide as it waits between front and back.
  typedef struct packed {
    op_t         op;
    logic        n_neg;
    logic        d_neg;
    logic        err;
    logic [15:0] hi_mag;
    logic [15:0] lo_mag;
    logic [15:0] d_mag;
  } qword_t;

endpackage

// ===== hdl/xdiv_front.sv =====
// Front end: accepts a divide and reduces it to magnitudes, signs and early faults.
module xdiv_front (
  input  logic               in_push,
  input  logic [1:0]         in_operation,
  input  logic [15:0]        in_dividend_high,
  input  logic [15:0]        in_dividend_low,
  input  logic [15:0]        in_divisor,
  input  logic               q_full,
  output logic               q_wr_en,
  output xdiv_pkg::qword_t   q_wdata
);

  logic [31:0] n_mag;
  logic [31:0] n_word;
  logic [15:0] d_mag;
  logic        min_fault;

  assign n_word  = {in_dividend_high, in_dividend_low};
  assign q_wr_en = in_push && !q_full;

  always_comb begin
    n_mag         = 32'h0;
    d_mag         = 16'h0;
    min_fault     = 1'b0;
    q_wdata       = '0;
    q_wdata.op    = xdiv_pkg::op_t'(in_operation);
    unique case (xdiv_pkg::op_t'(in_operation))
      xdiv_pkg::OP_DIVU8: begin
        n_mag = {16'h0, in_dividend_low};
        d_mag = {8'h0, in_divisor[7:0]};
      end
      xdiv_pkg::OP_DIVS8: begin
        q_wdata.n_neg = in_dividend_low[15];
        q_wdata.d_neg = in_divisor[7];
        n_mag = {16'h0, in_dividend_low[15] ? (16'h0 - in_dividend_low) : in_dividend_low};
        d_mag = {8'h0, in_divisor[7] ? (8'h0 - in_divisor[7:0]) : in_divisor[7:0]};
      end
      xdiv_pkg::OP_DIVU16: begin
        n_mag = n_word;
        d_mag = in_divisor;
      end
      xdiv_pkg::OP_DIVS16: begin
        q_wdata.n_neg = in_dividend_high[15];
        q_wdata.d_neg = in_divisor[15];
        n_mag     = in_dividend_high[15] ? (32'h0 - n_word) : n_word;
        d_mag     = in_divisor[15] ? (16'h0 - in_divisor) : in_divisor;
        min_fault = (n_word == xdiv_pkg::SW_MIN_DIVIDEND);
      end
    endcase
    q_wdata.hi_mag = n_mag[31:16];
    q_wdata.lo_mag = n_mag[15:0];
    q_wdata.d_mag  = d_mag;
    q_wdata.err    = (d_mag == 16'h0) || min_fault;
  end

endmodule

// ===== hdl/xdiv_fifo.sv =====
// Short queue that decouples the front end from the divider pipeline.
module xdiv_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  xdiv_pkg::qword_t wdata,
  input  logic             rd_en,
  output xdiv_pkg::qword_t rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  xdiv_pkg::qword_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full  = (count_r == FULL_CNT);
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== hdl/xdiv_back.sv =====
// Back end: sixteen-stage restoring divider, sign fix-up and output register.
module xdiv_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  xdiv_pkg::qword_t q_rdata,
  output logic             q_rd_en,
  output logic [15:0]      out_quotient,
  output logic [15:0]      out_remainder,
  output logic             out_divide_error,
  output logic             out_empty,
  input  logic             out_pop
);

  localparam int STEPS = 16;

  typedef struct packed {
    xdiv_pkg::op_t op;
    logic          n_neg;
    logic          d_neg;
    logic          err;
    logic [15:0]   rem;
    logic [15:0]   bits;
    logic [15:0]   dvs;
  } stage_t;

  // One quotient bit: the next dividend bit enters the partial remainder,
  // and the quotient bit enters at the bottom of the same shift word.
  function automatic stage_t step_f(stage_t s, logic first);
    logic [16:0] rem17;
    logic [16:0] diff;
    stage_t      o;
    o     = s;
    rem17 = {s.rem, s.bits[15]};
    diff  = rem17 - {1'b0, s.dvs};
    if (first && (s.rem >= s.dvs)) begin
      o.err = 1'b1;
    end
    o.bits = {s.bits[14:0], !diff[16]};
    o.rem  = diff[16] ? rem17[15:0] : diff[15:0];
    return o;
  endfunction

  stage_t        stg_r [STEPS+1];
  logic [STEPS:0] valid_r;
  logic          adv;
  logic          out_valid_r;
  logic [15:0]   quot_r, quot_nxt;
  logic [15:0]   rem_r, rem_nxt;
  logic          err_r, err_nxt;
  stage_t        fin;
  logic          q_neg;
  logic          ovf;
  logic [15:0]   q_fix;
  logic [15:0]   r_fix;
  logic          byte_op;

  // The whole pipe moves together whenever the output register can take a word.
  assign adv     = !out_valid_r || out_pop;
  assign q_rd_en = adv && q_valid;

  always_ff @(posedge clk) begin
    if (adv) begin
      stg_r[0].op    <= q_rdata.op;
      stg_r[0].n_neg <= q_rdata.n_neg;
      stg_r[0].d_neg <= q_rdata.d_neg;
      stg_r[0].err   <= q_rdata.err;
      stg_r[0].rem   <= q_rdata.hi_mag;
      stg_r[0].bits  <= q_rdata.lo_mag;
      stg_r[0].dvs   <= q_rdata.d_mag;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (adv) begin
        stg_r[k+1] <= step_f(stg_r[k], (k == 0));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= {valid_r[STEPS-1:0], q_valid};
    end
  end

  assign fin     = stg_r[STEPS];
  assign q_neg   = fin.n_neg ^ fin.d_neg;
  assign byte_op = !fin.op[1];

  always_comb begin
    unique case (fin.op)
      xdiv_pkg::OP_DIVU8:  ovf = (fin.bits[15:8] != 8'h0);
      xdiv_pkg::OP_DIVS8:  ovf = q_neg ? (fin.bits > xdiv_pkg::SB_Q_NEG_MAX)
                                       : (fin.bits > xdiv_pkg::SB_Q_POS_MAX);
      xdiv_pkg::OP_DIVU16: ovf = 1'b0;
      xdiv_pkg::OP_DIVS16: ovf = q_neg ? (fin.bits > xdiv_pkg::SW_Q_NEG_MAX)
                                       : (fin.bits > xdiv_pkg::SW_Q_POS_MAX);
    endcase
    q_fix = q_neg ? (16'h0 - fin.bits) : fin.bits;
    r_fix = fin.n_neg ? (16'h0 - fin.rem) : fin.rem;
    if (byte_op) begin
      q_fix[15:8] = 8'h0;
      r_fix[15:8] = 8'h0;
    end
    err_nxt  = fin.err || ovf;
    quot_nxt = err_nxt ? 16'h0 : q_fix;
    rem_nxt  = err_nxt ? 16'h0 : r_fix;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= valid_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
      err_r  <= err_nxt;
    end
  end

  assign out_quotient     = quot_r;
  assign out_remainder    = rem_r;
  assign out_divide_error = err_r;
  assign out_empty        = !out_valid_r;

endmodule

// ===== hdl/x86_div_idiv_unit.sv =====
// Top level of the 8/16-bit signed and unsigned divide unit.
//
//   port group   direction  handshake        payload
//   in_          input      in_push/in_full  operation, dividend_high, dividend_low, divisor
//   out_         output     out_empty/out_pop quotient, remainder, divide_error
//
// A pushed word passes through the queue, the first divider stage, sixteen quotient-bit
// stages and the output register on its way to the result ports. A new word may be pushed
// every cycle while in_full is low.
// Reset clears the queue and all stage valid bits; in_full is low right after reset.
// While a result waits unpopped the divider stages hold; the queue keeps taking words
// until its QUEUE_DEPTH entries are used, and in_full then stays high until the pipe moves.
module x86_div_idiv_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_dividend_high,
  input  logic [15:0] in_dividend_low,
  input  logic [15:0] in_divisor,
  output logic [15:0] out_quotient,
  output logic [15:0] out_remainder,
  output logic        out_divide_error,
  output logic        out_empty,
  input  logic        out_pop
);

  xdiv_pkg::qword_t q_wdata;
  xdiv_pkg::qword_t q_rdata;
  logic             q_wr_en;
  logic             q_rd_en;
  logic             q_full;
  logic             q_empty;

  assign in_full = q_full;

  xdiv_front u_front (
    .in_push          (in_push),
    .in_operation     (in_operation),
    .in_dividend_high (in_dividend_high),
    .in_dividend_low  (in_dividend_low),
    .in_divisor       (in_divisor),
    .q_full           (q_full),
    .q_wr_en          (q_wr_en),
    .q_wdata          (q_wdata)
  );

  xdiv_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (q_wr_en),
    .wdata (q_wdata),
    .rd_en (q_rd_en),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  xdiv_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (!q_empty),
    .q_rdata          (q_rdata),
    .q_rd_en          (q_rd_en),
    .out_quotient     (out_quotient),
    .out_remainder    (out_remainder),
    .out_divide_error (out_divide_error),
    .out_empty        (out_empty),
    .out_pop          (out_pop)
  );

endmodule

// ===== hdl/xdiv_checker.sv =====
// Port-level checker for the divide unit, bound to its top level.
`include "x86_div_idiv_unit_defines.svh"

module xdiv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_push,
  input logic        in_full,
  input logic [1:0]  in_operation,
  input logic [15:0] in_dividend_high,
  input logic [15:0] in_dividend_low,
  input logic [15:0] in_divisor,
  input logic [15:0] out_quotient,
  input logic [15:0] out_remainder,
  input logic        out_divide_error,
  input logic        out_empty,
  input logic        out_pop
);

  // A faulted divide never leaks a partial quotient or remainder.
  `XDIV_ASSERT_SAME(a_err_zero, clk, rst_n, !out_empty && out_divide_error, out_quotient == 16'h0 && out_remainder == 16'h0, "divide error with non-zero result")

  // A waiting result word stays put until it is popped.
  `XDIV_ASSERT_NEXT(a_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_quotient) && $stable(out_remainder) && $stable(out_divide_error), "unpopped result changed")

  // Reset empties both sides, and out_empty stays high while no word can yet have crossed the pipe.
  `XDIV_ASSERT_RESET(a_reset, clk, (!rst_n |=> !in_full && out_empty ##1 out_empty ##1 out_empty), "result or full flag too soon after reset")

endmodule

bind x86_div_idiv_unit xdiv_checker u_xdiv_checker (.*);
